### rtl/core/page_framebuffer_draw_engine_defines.svh
// assertion macros for the draw engine
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

`define PFDE_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PFDE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/pfde_pkg.sv
package pfde_pkg;
  localparam int DefWidth  = 84;
  localparam int DefHeight = 48;

  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_CLR    = 3'd1;
  localparam logic [2:0] MODE_GLYPH  = 3'd2;
  localparam logic [2:0] MODE_SCROLL = 3'd3;
  localparam logic [2:0] MODE_FILL   = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  localparam logic [1:0] ATTR_INV  = 2'd1;
  localparam logic [1:0] ATTR_ULIN = 2'd2;

  localparam logic [7:0] UNDERLINE_BIT = 8'b10000000;
  localparam logic [7:0] BYTE_MASK     = 8'hff;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       rd_a;
    logic       rd_b;
    logic       wr_a;
    logic       wr_b;
    logic       scr_rd;
    logic       scr_wr;
    logic       fill_wr;
    logic       rd_out;
    logic       emit;
  } pfde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       sweep_last;
    logic       page_last;
    logic       two_pages;
    logic       in_range;
  } pfde_stat_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction
endpackage

### rtl/core/pfde_ctrl.sv
module pfde_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0]            in_mode,
  input  pfde_pkg::pfde_stat_t  stat,
  output logic                  busy,
  output pfde_pkg::pfde_cmd_t   cmd
);
  import pfde_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDA    = 4'd2;
  localparam logic [3:0] S_WRA    = 4'd3;
  localparam logic [3:0] S_WRB    = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_SCR    = 4'd6;
  localparam logic [3:0] S_SCRW   = 4'd7;
  localparam logic [3:0] S_FILL   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_RDB    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mode_r  <= MODE_SET;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          mode_nxt = in_mode;
          case (in_mode)
            MODE_SET, MODE_CLR, MODE_GLYPH: state_nxt = S_RDA;
            MODE_READ:   state_nxt = S_READ;
            MODE_SCROLL: state_nxt = S_SCR;
            MODE_FILL:   state_nxt = S_FILL;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_RDA: begin
        cmd.rd_a = 1'b1;
        state_nxt = S_WRA;
      end
      S_WRA: begin
        cmd.wr_a = 1'b1;
        if (stat.two_pages && mode_r == MODE_GLYPH) begin
          state_nxt = S_RDB;
        end else begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RDB: begin
        cmd.rd_b = 1'b1;
        state_nxt = S_WRB;
      end
      S_WRB: begin
        cmd.wr_b = 1'b1;
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        cmd.rd_out = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCR: begin
        cmd.scr_rd = 1'b1;
        if (stat.page_last) state_nxt = S_SCRW;
      end
      S_SCRW: begin
        cmd.scr_wr = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
        else if (stat.page_last) state_nxt = S_SCR;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### rtl/core/pfde_dp.sv
module pfde_dp #(
  parameter int Width  = pfde_pkg::DefWidth,
  parameter int Height = pfde_pkg::DefHeight
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfde_pkg::pfde_cmd_t   cmd,
  input  logic [2:0]            in_mode,
  input  logic [7:0]            in_x_pos,
  input  logic [7:0]            in_y_pos,
  input  logic [7:0]            in_pixel_byte,
  input  logic [1:0]            in_glyph_attr,
  input  logic signed [6:0]     in_shift,
  input  logic [8:0]            in_read_index,
  input  logic                  rotated,
  output pfde_pkg::pfde_stat_t  stat,
  output logic                  out_strobe,
  output logic [7:0]            out_read_data,
  output logic [2:0]            out_done_mode
);
  import pfde_pkg::*;

  localparam int Pages = Height / 8;
  localparam int Bytes = Width * Pages;
  localparam int AW    = $clog2(Bytes);
  localparam int XW    = $clog2(Width);
  localparam int PW    = $clog2(Pages + 1);

  logic [7:0] mem [Bytes];

  logic [2:0]    mode_r;
  logic [7:0]    x_r, y_r, byte_r;
  logic [1:0]    attr_r;
  logic [8:0]    idx_r;
  logic          neg_r;
  logic [2:0]    bits_r;
  logic [PW-1:0] pg8_r;
  logic          big_r, zero_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] waddr_r;
  logic [7:0]    rdata_r;
  logic [XW-1:0] col_r;
  logic [PW-1:0] pcnt_r;
  logic [7:0]    colbuf_r [Pages];
  logic          strobe_r;
  logic [7:0]    odata_r;
  logic [2:0]    omode_r;

  logic [6:0]  mag;
  logic [AW:0] base_a;
  logic [7:0]  gcol;

  assign mag = in_shift[6] ? 7'(-in_shift) : 7'(in_shift);
  assign base_a = (AW+1)'(x_r) + (AW+1)'(Width) * (AW+1)'(y_r[7:3]);

  always_comb begin
    gcol = byte_r;
    if (attr_r == ATTR_INV) gcol = byte_r ^ BYTE_MASK;
    else if (attr_r == ATTR_ULIN) gcol = byte_r | UNDERLINE_BIT;
  end

  // sweep end for clear and fill uses write address
  assign stat.in_range   = (32'(x_r) < Width) && (32'(y_r[7:3]) < Pages);
  assign stat.two_pages  = stat.in_range && (y_r[2:0] != 3'd0) &&
                           (32'(y_r[7:3]) + 1 < Pages);
  assign stat.page_last  = (32'(pcnt_r) == Pages - 1);
  assign stat.sweep_last = cmd.scr_wr ? (stat.page_last && 32'(col_r) == Width - 1)
                                      : (32'(waddr_r) == Bytes - 1);

  // scroll source for page p of current column buffer
  function automatic logic [7:0] src_pg(input logic [PW-1:0] p, input logic signed [PW+1:0] o);
    logic signed [PW+2:0] s;
    s = $signed({1'b0, p}) + o;
    if (s < 0 || s >= Pages) return 8'd0;
    return colbuf_r[s[PW-1:0]];
  endfunction

  logic signed [PW+1:0] o1, o2;
  logic [7:0] b1, b2, scr_byte;
  logic [3:0] inv_bits;
  always_comb begin
    inv_bits = 4'd8 - 4'(bits_r);
    if (!neg_r) begin
      o1 = $signed({2'b00, pg8_r});
      o2 = o1 + 1;
    end else begin
      o1 = -$signed({2'b00, pg8_r});
      o2 = o1 - 1;
    end
    b1 = src_pg(pcnt_r, o1);
    b2 = src_pg(pcnt_r, o2);
    if (big_r) scr_byte = 8'd0;
    else if (zero_r) scr_byte = colbuf_r[pcnt_r[PW-1:0]];
    else if (!neg_r) scr_byte = 8'((16'(b1) >> bits_r) | (16'(b2) << inv_bits));
    else scr_byte = 8'((16'(b1) << bits_r) | (16'(b2) >> inv_bits));
  end

  logic [AW-1:0] scr_addr;
  assign scr_addr = AW'(32'(col_r) + Width * 32'(pcnt_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      x_r    <= in_x_pos;
      y_r    <= in_y_pos;
      byte_r <= in_pixel_byte;
      attr_r <= in_glyph_attr;
      idx_r  <= in_read_index;
      neg_r  <= in_shift[6];
      bits_r <= mag[2:0];
      pg8_r  <= PW'(mag[5:3]);
      big_r  <= (32'(mag) >= Height);
      zero_r <= (mag == 7'd0);
      col_r  <= '0;
      pcnt_r <= '0;
    end
    if (cmd.rd_a) begin
      addr_r  <= base_a[AW-1:0];
      rdata_r <= mem[base_a[AW-1:0]];
    end
    if (cmd.rd_b) begin
      addr_r  <= AW'(32'(addr_r) + Width);
      rdata_r <= mem[AW'(32'(addr_r) + Width)];
    end
    if (cmd.rd_out) begin
      if (32'(idx_r) < Bytes)
        rdata_r <= rotated ? rev8(mem[AW'(Bytes - 1 - 32'(idx_r))]) : mem[AW'(idx_r)];
      else rdata_r <= 8'd0;
    end
    if (cmd.wr_a && stat.in_range) begin
      case (mode_r)
        MODE_SET: mem[addr_r] <= rdata_r | (8'd1 << y_r[2:0]);
        MODE_CLR: mem[addr_r] <= rdata_r & ~(8'd1 << y_r[2:0]);
        default:  mem[addr_r] <= (rdata_r & ~(BYTE_MASK << y_r[2:0])) | (gcol << y_r[2:0]);
      endcase
    end
    if (cmd.wr_b)
      mem[addr_r] <= (rdata_r & ~(BYTE_MASK >> (4'd8 - 4'(y_r[2:0])))) |
                     (gcol >> (4'd8 - 4'(y_r[2:0])));
    if (cmd.scr_rd) begin
      colbuf_r[pcnt_r[PW-1:0]] <= mem[scr_addr];
      pcnt_r <= stat.page_last ? '0 : pcnt_r + 1'b1;
    end
    if (cmd.scr_wr) begin
      mem[scr_addr] <= scr_byte;
      if (stat.page_last) begin
        pcnt_r <= '0;
        col_r  <= col_r + 1'b1;
      end else pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.clr_step || cmd.fill_wr) begin
      mem[waddr_r] <= cmd.fill_wr ? byte_r : 8'd0;
    end
    odata_r <= (mode_r == MODE_READ) ? rdata_r : 8'd0;
    omode_r <= mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waddr_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
      if (cmd.load) waddr_r <= '0;
      else if (cmd.clr_step || cmd.fill_wr)
        waddr_r <= (32'(waddr_r) == Bytes - 1) ? '0 : waddr_r + 1'b1;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_read_data = odata_r;
  assign out_done_mode = omode_r;
endmodule

### rtl/core/page_framebuffer_draw_engine.sv
// Draw engine for a page-organized monochrome framebuffer. A command is taken when start is
// high and busy is low; its single result appears on out_* for one cycle with out_strobe and
// must be taken then, as the receiver cannot stall. A pixel command or a byte read touches
// one byte, a glyph column one or two pages (one read-modify-write per page); scroll and
// fill walk the whole single-port store, scroll reading each column into a buffer first.
// After reset the store is cleared byte by byte while busy is high.
module page_framebuffer_draw_engine #(
  parameter int Width  = pfde_pkg::DefWidth,
  parameter int Height = pfde_pkg::DefHeight
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_mode,
  input  logic [7:0]        in_x_pos,
  input  logic [7:0]        in_y_pos,
  input  logic [7:0]        in_pixel_byte,
  input  logic [1:0]        in_glyph_attr,
  input  logic signed [6:0] in_shift,
  input  logic [8:0]        in_read_index,
  output logic              out_strobe,
  output logic [7:0]        out_read_data,
  output logic [2:0]        out_done_mode,
  input  logic              cfg_we,
  input  logic              cfg_rotated
);
  import pfde_pkg::*;
  `include "page_framebuffer_draw_engine_defines.svh"

  pfde_cmd_t  cmd;
  pfde_stat_t stat;
  logic       rotated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) rotated_r <= 1'b0;
    else if (cfg_we) rotated_r <= cfg_rotated;
  end

  pfde_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_mode, .stat, .busy, .cmd
  );

  pfde_dp #(.Width(Width), .Height(Height)) u_dp (
    .clk, .rst_n, .cmd, .in_mode, .in_x_pos, .in_y_pos, .in_pixel_byte,
    .in_glyph_attr, .in_shift, .in_read_index, .rotated(rotated_r), .stat,
    .out_strobe, .out_read_data, .out_done_mode
  );

  `PFDE_ASSERT_NEXT(a_emit_strobe, clk, rst_n, cmd.emit, out_strobe)
  `PFDE_ASSERT_IMPL(a_strobe_busy, clk, rst_n, out_strobe, !busy)
  `PFDE_ASSERT_IMPL(a_nonread_zero, clk, rst_n, out_strobe && out_done_mode != MODE_READ,
                    out_read_data == 8'd0)
endmodule

### verif/tb_page_framebuffer_draw_engine.sv
module tb_page_framebuffer_draw_engine;
  import pfde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Width  = DefWidth;
  localparam int Pages  = DefHeight / 8;
  localparam int StoreBytes = Width * Pages;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [1:0] ATTR_NORM = 2'd0;
  localparam logic [1:0] ATTR_ALT_NORM = 2'd3;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] done_mode;
  } draw_result_t;

  class draw_scoreboard;
    logic [7:0]   shadow[StoreBytes];
    logic         rotated;
    draw_result_t pending[$];
    int           mismatches;

    function void clear_store();
      foreach (shadow[i]) shadow[i] = '0;
    endfunction

    function void apply_pixel(int x, int y, bit set_it);
      int pos;
      if (x >= Width || y / 8 >= Pages) return;
      pos = x + Width * (y / 8);
      shadow[pos][y % 8] = set_it;
    endfunction

    function void apply_glyph(int x, int y, logic [7:0] bits, logic [1:0] attr);
      logic [15:0] col;
      logic [15:0] msk;
      int pos;
      int off;
      if (attr == ATTR_INV) bits = bits ^ BYTE_MASK;
      else if (attr == ATTR_ULIN) bits = bits | UNDERLINE_BIT;
      if (x >= Width || y / 8 >= Pages) return;
      off = y % 8;
      pos = x + Width * (y / 8);
      col = {8'h00, bits} << off;
      msk = 16'h00ff << off;
      shadow[pos] = (shadow[pos] & ~msk[7:0]) | col[7:0];
      if (off != 0 && y / 8 + 1 < Pages)
        shadow[pos + Width] = (shadow[pos + Width] & ~msk[15:8]) | col[15:8];
    endfunction

    function void apply_scroll(logic signed [6:0] amt);
      logic [7:0] col[Pages];
      logic [7:0] nxt[Pages];
      int mag;
      int pg;
      int bsh;
      int src;
      logic [15:0] pair;
      mag = (amt < 0) ? -amt : amt;
      pg = mag / 8;
      bsh = mag % 8;
      for (int x = 0; x < Width; x++) begin
        for (int p = 0; p < Pages; p++) col[p] = shadow[x + Width * p];
        for (int p = 0; p < Pages; p++) begin
          if (amt > 0) begin
            src = p + pg;
            pair[7:0]  = (src < Pages) ? col[src] : 8'h00;
            pair[15:8] = (src + 1 < Pages) ? col[src + 1] : 8'h00;
            pair = pair >> bsh;
            nxt[p] = pair[7:0];
          end else begin
            src = p - pg;
            pair[15:8] = (src >= 0 && src < Pages) ? col[src] : 8'h00;
            pair[7:0]  = (src - 1 >= 0 && src - 1 < Pages) ? col[src - 1] : 8'h00;
            pair = pair << bsh;
            nxt[p] = pair[15:8];
          end
        end
        for (int p = 0; p < Pages; p++) shadow[x + Width * p] = nxt[p];
      end
    endfunction

    function void note_command(logic [2:0] mode, logic [7:0] x, logic [7:0] y,
                               logic [7:0] bits, logic [1:0] attr,
                               logic signed [6:0] amt, logic [8:0] idx);
      draw_result_t r;
      logic [7:0] b;
      r.read_data = '0;
      r.done_mode = mode;
      case (mode)
        MODE_SET:    apply_pixel(x, y, 1'b1);
        MODE_CLR:    apply_pixel(x, y, 1'b0);
        MODE_GLYPH:  apply_glyph(x, y, bits, attr);
        MODE_SCROLL: apply_scroll(amt);
        MODE_FILL:   foreach (shadow[i]) shadow[i] = bits;
        MODE_READ: begin
          if (idx < StoreBytes) begin
            if (rotated) begin
              b = shadow[StoreBytes - 1 - idx];
              for (int k = 0; k < 8; k++) r.read_data[k] = b[7 - k];
            end else begin
              r.read_data = shadow[idx];
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(draw_result_t got);
      draw_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result mode=%0d data=%h",
                                       got.done_mode, got.read_data);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected mode=%0d data=%h, actual mode=%0d data=%h",
                   exp_r.done_mode, exp_r.read_data, got.done_mode, got.read_data);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_mode;
  logic [7:0] in_x_pos;
  logic [7:0] in_y_pos;
  logic [7:0] in_pixel_byte;
  logic [1:0] in_glyph_attr;
  logic signed [6:0] in_shift;
  logic [8:0] in_read_index;
  logic out_strobe;
  logic [7:0] out_read_data;
  logic [2:0] out_done_mode;
  logic cfg_we;
  logic cfg_rotated;

  draw_scoreboard sb;

  page_framebuffer_draw_engine u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_x_pos(in_x_pos), .in_y_pos(in_y_pos),
    .in_pixel_byte(in_pixel_byte), .in_glyph_attr(in_glyph_attr),
    .in_shift(in_shift), .in_read_index(in_read_index),
    .out_strobe(out_strobe), .out_read_data(out_read_data),
    .out_done_mode(out_done_mode), .cfg_we(cfg_we), .cfg_rotated(cfg_rotated)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result({out_read_data, out_done_mode});
  end

  task automatic send_command(logic [2:0] mode, logic [7:0] x, logic [7:0] y,
                              logic [7:0] bits, logic [1:0] attr,
                              logic signed [6:0] amt, logic [8:0] idx);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_x_pos <= x;
    in_y_pos <= y;
    in_pixel_byte <= bits;
    in_glyph_attr <= attr;
    in_shift <= amt;
    in_read_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_command(mode, x, y, bits, attr, amt, idx);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rotated(logic v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_rotated <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rotated = v;
  endtask

  task automatic random_command();
    logic [2:0] mode;
    int r;
    logic [7:0] x;
    logic [7:0] y;
    logic [8:0] idx;
    logic signed [6:0] amt;
    r = $urandom_range(0, 99);
    if (r < 25) mode = MODE_SET;
    else if (r < 35) mode = MODE_CLR;
    else if (r < 55) mode = MODE_GLYPH;
    else if (r < 57) mode = MODE_SCROLL;
    else if (r < 58) mode = MODE_FILL;
    else if (r < 97) mode = MODE_READ;
    else mode = 3'($urandom_range(6, 7));
    x = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, Width - 1));
    y = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 47));
    idx = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, StoreBytes - 1));
    amt = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($signed($urandom_range(0, 94)) - 47);
    send_command(mode, x, y, 8'($urandom), 2'($urandom), amt, idx);
  endtask

  initial begin
    sb = new();
    sb.clear_store();
    sb.rotated = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = '0;
    in_x_pos = '0;
    in_y_pos = '0;
    in_pixel_byte = '0;
    in_glyph_attr = '0;
    in_shift = '0;
    in_read_index = '0;
    cfg_we = 1'b0;
    cfg_rotated = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_command(MODE_SET, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SET, 8'd83, 8'd47, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SET, 8'd84, 8'd3, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SET, 8'd5, 8'd48, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SET, 8'd255, 8'd255, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_CLR, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_GLYPH, 8'd10, 8'd13, 8'hA5, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_GLYPH, 8'd11, 8'd16, 8'h3C, ATTR_INV, 7'sd0, 9'd0);
    send_command(MODE_GLYPH, 8'd12, 8'd45, 8'h0F, ATTR_ULIN, 7'sd0, 9'd0);
    send_command(MODE_GLYPH, 8'd13, 8'd7, 8'hFF, ATTR_ALT_NORM, 7'sd0, 9'd0);
    send_command(MODE_GLYPH, 8'd84, 8'd0, 8'hFF, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_GLYPH, 8'd1, 8'd200, 8'hFF, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_READ, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd10 + 9'd84);
    send_command(MODE_READ, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd503);
    send_command(MODE_READ, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd504);
    send_command(MODE_READ, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd511);
    send_command(MODE_SCROLL, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SCROLL, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd3, 9'd0);
    send_command(MODE_SCROLL, 8'd0, 8'd0, 8'h00, ATTR_NORM, -7'sd11, 9'd0);
    send_command(MODE_READ, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd94);
    send_command(MODE_SPARE_A, 8'hFF, 8'hFF, 8'hFF, 2'd3, -7'sd1, 9'h1FF);
    send_command(MODE_SPARE_B, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SCROLL, 8'd0, 8'd0, 8'h00, ATTR_NORM, 7'sd63, 9'd0);
    send_command(MODE_FILL, 8'd0, 8'd0, 8'h5A, ATTR_NORM, 7'sd0, 9'd0);
    send_command(MODE_SCROLL, 8'd0, 8'd0, 8'h00, ATTR_NORM, -7'sd64, 9'd0);

    for (int ph = 0; ph < 4; ph++) begin
      write_rotated(ph[0]);
      for (int i = 0; i < 450; i++) random_command();
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/pfde_pkg.sv
rtl/core/pfde_ctrl.sv
rtl/core/pfde_dp.sv
rtl/core/page_framebuffer_draw_engine.sv
verif/tb_page_framebuffer_draw_engine.sv
